>>> design/fct_pkg.sv
// Package: shared types and constants for the frustum cull test
package fct_pkg;
   localparam int unsigned NUM_REGS = 6;
   localparam int unsigned REG_W = 64;
   localparam int unsigned IDX_W = 3;
   localparam int unsigned COORD_W = 20;
   localparam int unsigned EXT_W = 21;   // coordinate after p+q / p-q
   localparam int unsigned PROD_W = 37;  // 16 x 21 signed product
   localparam int unsigned SUM_W = 40;   // plane value, 22 fractional bits

   localparam logic [1:0] FUNC_POINT = 2'd0;
   localparam logic [1:0] FUNC_SPHERE = 2'd1;
   localparam logic [1:0] FUNC_BOX_CE = 2'd2;
   localparam logic [1:0] FUNC_BOX_MM = 2'd3;

   typedef logic signed [EXT_W-1:0] coord_type;
   typedef logic signed [SUM_W-1:0] sum_type;
endpackage

>>> design/fct_plane.sv
// Per-plane evaluator: products, sums and pass decision for one plane, three stages
module fct_plane (
   input  logic                       clock,
   input  logic [fct_pkg::REG_W-1:0]  plane,
   input  logic [1:0]                 func,
   input  fct_pkg::coord_type         lo [3],
   input  fct_pkg::coord_type         hi [3],
   input  fct_pkg::sum_type           thr,
   output logic                       pass_out
);
   // stage A: products per axis for both ends
   logic signed [fct_pkg::PROD_W-1:0] plo_ff [3];
   logic signed [fct_pkg::PROD_W-1:0] phi_ff [3];
   fct_pkg::sum_type d_ff, thr_ff;
   logic [1:0] func_ff;
   // stage B: corner sums
   fct_pkg::sum_type csum_ff [8];
   fct_pkg::sum_type thr2_ff;
   logic [1:0] func2_ff;
   logic pass_ff;

   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         plo_ff[j] <= fct_pkg::PROD_W'($signed(plane[16*j +: 16]))
                    * fct_pkg::PROD_W'(lo[j]);
         phi_ff[j] <= fct_pkg::PROD_W'($signed(plane[16*j +: 16]))
                    * fct_pkg::PROD_W'(hi[j]);
      end
      d_ff <= fct_pkg::SUM_W'($signed({plane[63:48], 18'd0}));
      thr_ff <= thr;
      func_ff <= func;
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 8; k++) begin
         csum_ff[k] <= fct_pkg::SUM_W'((k & 1) != 0 ? phi_ff[0] : plo_ff[0])
                     + fct_pkg::SUM_W'((k & 2) != 0 ? phi_ff[1] : plo_ff[1])
                     + fct_pkg::SUM_W'((k & 4) != 0 ? phi_ff[2] : plo_ff[2])
                     + d_ff;
      end
      thr2_ff <= thr_ff;
      func2_ff <= func_ff;
   end

   logic pass_in;
   always_comb begin
      pass_in = 1'b0;
      if (func2_ff == fct_pkg::FUNC_POINT || func2_ff == fct_pkg::FUNC_SPHERE) begin
         pass_in = (csum_ff[0] >= thr2_ff);
      end else begin
         for (int k = 0; k < 8; k++) begin
            if (csum_ff[k] >= 0) pass_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      pass_ff <= pass_in;
   end
   assign pass_out = pass_ff;
endmodule

>>> design/frustum_cull_test.sv
// Top level: six-plane frustum cull test with a register file of planes
// Pipeline from start to rsp_valid: input reg, 3 plane stages, output AND register.
// Throughput: one transaction per cycle, no stalls; every stage carries a valid bit.
// Reset: synchronous active high; clears plane registers to zero and the valid pipe.
// All planes are evaluated in parallel, one evaluator per plane.
// Receiver cannot stall; rsp_inside_res is valid only while rsp_valid is high.
module frustum_cull_test #(
   parameter int unsigned PLANES = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_func,
   input  logic signed [fct_pkg::COORD_W-1:0] req_px,
   input  logic signed [fct_pkg::COORD_W-1:0] req_py,
   input  logic signed [fct_pkg::COORD_W-1:0] req_pz,
   input  logic signed [fct_pkg::COORD_W-1:0] req_qx,
   input  logic signed [fct_pkg::COORD_W-1:0] req_qy,
   input  logic signed [fct_pkg::COORD_W-1:0] req_qz,
   output logic                              rsp_valid,
   output logic                              rsp_inside_res,
   input  logic                              csr_we,
   input  logic [fct_pkg::IDX_W-1:0]         csr_index,
   input  logic [fct_pkg::REG_W-1:0]         csr_wdata
);
   logic [fct_pkg::REG_W-1:0] plane_ff [fct_pkg::NUM_REGS];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < fct_pkg::NUM_REGS; i++) plane_ff[i] <= '0;
      end else if (csr_we && csr_index < fct_pkg::IDX_W'(fct_pkg::NUM_REGS)) begin
         plane_ff[csr_index] <= csr_wdata;
      end
   end

   assign busy = 1'b0;

   // input stage: corners and sphere threshold
   fct_pkg::coord_type lo_ff [3], hi_ff [3];
   fct_pkg::sum_type thr_ff;
   logic [1:0] func_ff;
   logic [4:0] vld_ff;
   logic signed [fct_pkg::COORD_W-1:0] p [3], q [3];
   assign p = '{req_px, req_py, req_pz};
   assign q = '{req_qx, req_qy, req_qz};

   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         if (req_func == fct_pkg::FUNC_BOX_CE) begin
            lo_ff[j] <= fct_pkg::EXT_W'(p[j]) - fct_pkg::EXT_W'(q[j]);
            hi_ff[j] <= fct_pkg::EXT_W'(p[j]) + fct_pkg::EXT_W'(q[j]);
         end else begin
            lo_ff[j] <= fct_pkg::EXT_W'(p[j]);
            hi_ff[j] <= fct_pkg::EXT_W'(q[j]);
         end
      end
      // sphere needs value >= -r; point needs value >= 0
      thr_ff <= (req_func == fct_pkg::FUNC_SPHERE)
              ? -fct_pkg::SUM_W'($signed({req_qx, 14'd0})) : '0;
      func_ff <= req_func;
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else vld_ff <= {vld_ff[3:0], start};
   end

   logic [PLANES-1:0] pass;
   for (genvar g = 0; g < PLANES; g++) begin : g_plane
      fct_plane u_plane (
         .clock    (clock),
         .plane    (plane_ff[g]),
         .func     (func_ff),
         .lo       (lo_ff),
         .hi       (hi_ff),
         .thr      (thr_ff),
         .pass_out (pass[g])
      );
   end

   logic inside_ff;
   always_ff @(posedge clock) begin
      inside_ff <= &pass;
   end

   assign rsp_valid = vld_ff[4];
   assign rsp_inside_res = inside_ff;
endmodule

>>> bench/fct_checker.sv
// Checker: predicts the cull verdict per request and compares with each response
module fct_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  logic [1:0]                         req_func,
   input  logic signed [fct_pkg::COORD_W-1:0] req_px,
   input  logic signed [fct_pkg::COORD_W-1:0] req_py,
   input  logic signed [fct_pkg::COORD_W-1:0] req_pz,
   input  logic signed [fct_pkg::COORD_W-1:0] req_qx,
   input  logic signed [fct_pkg::COORD_W-1:0] req_qy,
   input  logic signed [fct_pkg::COORD_W-1:0] req_qz,
   input  logic                               rsp_valid,
   input  logic                               rsp_inside_res,
   input  logic                               csr_we,
   input  logic [fct_pkg::IDX_W-1:0]          csr_index,
   input  logic [fct_pkg::REG_W-1:0]          csr_wdata,
   output int                                 fail_count,
   output int                                 pending_count,
   output int                                 verdict_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [fct_pkg::REG_W-1:0] planes [fct_pkg::NUM_REGS];
   logic                      inside_queue [$];

   // plane value with 22 fractional bits, exact in 64 bits
   function automatic longint plane_eval(logic [fct_pkg::REG_W-1:0] pl, longint x,
                                         longint y, longint z);
      longint a, b, c, d;
      a = longint'($signed(pl[15:0]));
      b = longint'($signed(pl[31:16]));
      c = longint'($signed(pl[47:32]));
      d = longint'($signed(pl[63:48]));
      return a * x + b * y + c * z + d * 262144;
   endfunction

   function automatic logic cull_verdict(logic [1:0] func, longint p [3], longint q [3]);
      longint lo [3], hi [3];
      logic   ok;
      for (int j = 0; j < 3; j++) begin
         if (func == fct_pkg::FUNC_BOX_CE) begin
            lo[j] = p[j] - q[j];
            hi[j] = p[j] + q[j];
         end else begin
            lo[j] = p[j];
            hi[j] = q[j];
         end
      end
      for (int i = 0; i < fct_pkg::NUM_REGS; i++) begin
         case (func)
            fct_pkg::FUNC_POINT:
               ok = plane_eval(planes[i], p[0], p[1], p[2]) >= 0;
            fct_pkg::FUNC_SPHERE:
               ok = plane_eval(planes[i], p[0], p[1], p[2]) >= -(q[0] * 16384);
            default: begin
               ok = 1'b0;
               for (int k = 0; k < 8; k++)
                  if (plane_eval(planes[i], k[0] ? hi[0] : lo[0], k[1] ? hi[1] : lo[1],
                                 k[2] ? hi[2] : lo[2]) >= 0)
                     ok = 1'b1;
            end
         endcase
         if (!ok) return 1'b0;
      end
      return 1'b1;
   endfunction

   assign pending_count = inside_queue.size();

   always @(posedge clock) begin
      longint p [3], q [3];
      logic   want;
      if (reset) begin
         for (int i = 0; i < fct_pkg::NUM_REGS; i++) planes[i] <= '0;
         inside_queue.delete();
         fail_count <= 0;
         verdict_count <= 0;
      end else begin
         if (start && !busy) begin
            p[0] = req_px; p[1] = req_py; p[2] = req_pz;
            q[0] = req_qx; q[1] = req_qy; q[2] = req_qz;
            inside_queue.push_back(cull_verdict(req_func, p, q));
         end
         if (rsp_valid) begin
            verdict_count <= verdict_count + 1;
            if (inside_queue.size() == 0) begin
               if (fail_count < 10) $display("unexpected response transaction");
               fail_count <= fail_count + 1;
            end else begin
               want = inside_queue.pop_front();
               if (want !== rsp_inside_res) begin
                  if (fail_count < 10)
                     $display("inside_res mismatch: expected %0b got %0b", want,
                              rsp_inside_res);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (csr_we && csr_index < fct_pkg::NUM_REGS) planes[csr_index] <= csr_wdata;
      end
   end
endmodule

>>> bench/tb_top.sv
// Testbench top: stimulus, plane setup and verdict for the frustum cull test
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               start = 1'b0;
   logic                               busy;
   logic [1:0]                         req_func = '0;
   logic signed [fct_pkg::COORD_W-1:0] req_px = '0, req_py = '0, req_pz = '0;
   logic signed [fct_pkg::COORD_W-1:0] req_qx = '0, req_qy = '0, req_qz = '0;
   logic                               rsp_valid, rsp_inside_res;
   logic                               csr_we = 1'b0;
   logic [fct_pkg::IDX_W-1:0]          csr_index = '0;
   logic [fct_pkg::REG_W-1:0]          csr_wdata = '0;
   int                                 fail_count, pending_count, verdict_count;
   int                                 sent = 0;
   int                                 idle_pct = 0;

   always #2 clock = ~clock;

   frustum_cull_test i_dut (.*);

   fct_checker i_checker (.*);

   // start stays high after the last transaction; drain drops it
   task automatic send_query(logic [1:0] f, logic signed [fct_pkg::COORD_W-1:0] px, py,
                             pz, qx, qy, qz);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_func <= f;
      req_px <= px; req_py <= py; req_pz <= pz;
      req_qx <= qx; req_qy <= qy; req_qz <= qz;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent++;
   endtask

   // random coordinate: mostly near the origin so plane tests go both ways
   function automatic logic signed [fct_pkg::COORD_W-1:0] rand_coord();
      case ($urandom_range(9))
         0:       return fct_pkg::COORD_W'($urandom);
         1:       return $urandom_range(1) ? 20'sh7ffff : 20'sh80000;
         default: return $signed(20'($urandom_range(8191))) - 20'sd4096;
      endcase
   endfunction

   task automatic drain();
      start <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_plane(int idx, logic [fct_pkg::REG_W-1:0] v);
      csr_we <= 1'b1;
      csr_index <= fct_pkg::IDX_W'(idx);
      csr_wdata <= v;
      @(posedge clock);
   endtask

   // plane set: 0 zero, 1 extremes, 2 fully random, else random small box-like frustum
   task automatic load_planes(int kind);
      logic [fct_pkg::REG_W-1:0] v;
      for (int i = 0; i < fct_pkg::NUM_REGS; i++) begin
         case (kind)
            0: v = '0;
            1: v = (i % 2) ? 64'h8000_8000_8000_8000 : 64'h7fff_7fff_7fff_7fff;
            2: v = {$urandom, $urandom};
            default: begin
               v[15:0]  = 16'($urandom_range(16383) - 8192);
               v[31:16] = 16'($urandom_range(16383) - 8192);
               v[47:32] = 16'($urandom_range(16383) - 8192);
               v[63:48] = 16'($urandom_range(2047));
            end
         endcase
         write_plane(i, v);
      end
      csr_we <= 1'b0;
   endtask

   task automatic random_queries(int n);
      for (int k = 0; k < n; k++)
         send_query(2'($urandom), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                    rand_coord(), rand_coord());
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: zero planes, every function, field extremes
      for (int f = 0; f < 4; f++) begin
         send_query(2'(f), 20'sh7ffff, 20'sh80000, 20'sh7ffff, 20'sh80000, 20'sh7ffff,
                    20'sh80000);
         send_query(2'(f), 20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0);
      end
      drain();
      load_planes(3);
      // negative radius, negative half-extent, swapped min/max
      send_query(fct_pkg::FUNC_SPHERE, 20'sd0, 20'sd0, 20'sd0, -20'sd256, 20'sd0, 20'sd0);
      send_query(fct_pkg::FUNC_SPHERE, 20'sd100, -20'sd50, 20'sd20, 20'sd512, 20'sd0,
                 20'sd0);
      send_query(fct_pkg::FUNC_BOX_CE, 20'sd10, 20'sd20, 20'sd30, -20'sd300, -20'sd40,
                 20'sd50);
      send_query(fct_pkg::FUNC_BOX_CE, 20'sd10, 20'sd20, 20'sd30, 20'sd300, 20'sd40,
                 20'sd50);
      send_query(fct_pkg::FUNC_BOX_MM, 20'sd500, 20'sd400, 20'sd300, -20'sd500,
                 -20'sd400, -20'sd300);
      send_query(fct_pkg::FUNC_BOX_MM, -20'sd500, -20'sd400, -20'sd300, 20'sd500,
                 20'sd400, 20'sd300);
      for (int f = 0; f < 4; f++)
         send_query(2'(f), 20'sh80000, 20'sh80000, 20'sh80000, 20'sh7ffff, 20'sh7ffff,
                    20'sh7ffff);
      drain();
      load_planes(1);
      for (int f = 0; f < 4; f++)
         send_query(2'(f), 20'sh7ffff, 20'sh7ffff, 20'sh7ffff, 20'sh80000, 20'sh80000,
                    20'sh80000);
      drain();
      // random phases: sender idles 23%, then 80%, then not at all
      idle_pct = 23;
      load_planes(3);
      random_queries(350);
      drain();
      load_planes(2);
      random_queries(100);
      drain();
      idle_pct = 80;
      load_planes(3);
      random_queries(350);
      drain();
      idle_pct = 0;
      load_planes(3);
      random_queries(350);
      drain();
      load_planes(0);
      random_queries(100);
      drain();
      load_planes(3);
      random_queries(150);
      drain();
      $display("sent %0d requests over several plane sets (zero, extreme, random)", sent);
      $display("checked %0d responses for point, sphere and both box forms", verdict_count);
      if (fail_count == 0 && pending_count == 0)
         $display("frustum_cull_test test passed");
      else
         $display("frustum_cull_test test failed");
      $finish;
   end

   initial begin
      #2ms;
      $display("frustum_cull_test test failed");
      $finish;
   end
endmodule
